// ----- sv/lprd_pkg.sv -----
// Shared types and constants of the length-prefixed request deframer.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lprd_pkg;

    // Default width of the body length, position and byte counters.
    localparam int MSG_LEN_BITS_DEF = 21;

    // Configuration register widths, indexes and reset values.
    localparam int MAX_MSG_BITS = 21;
    localparam int MAX_ARG_BITS = 13;
    localparam int CFG_DATA_BITS = 21;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_MSG_LEN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ARG_CNT = 2'd1;
    localparam logic [MAX_MSG_BITS-1:0] MAX_MSG_RESET = 21'd4096;
    localparam logic [MAX_ARG_BITS-1:0] MAX_ARG_RESET = 13'd1024;

    // Result queue: up to two results per input byte, one leaves per cycle while the output is ready.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    typedef enum logic [2:0] {
        PH_LEN    = 3'd0,
        PH_COUNT  = 3'd1,
        PH_ARGLEN = 3'd2,
        PH_DATA   = 3'd3,
        PH_CLOSED = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        K_DATA  = 2'd0,
        K_START = 2'd1,
        K_DONE  = 2'd2,
        K_ERR   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        E_NONE      = 3'd0,
        E_TOO_LONG  = 3'd1,
        E_TOO_MANY  = 3'd2,
        E_OVERRUN   = 3'd3,
        E_TRAILING  = 3'd4,
        E_TOO_SHORT = 3'd5
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [11:0] arg_index;
        logic [20:0] arg_length;
        logic        last_of_arg;
        err_t        error_code;
        logic        last_of_run;
    } res_t;

    // Results produced by one accepted byte, handed from parser to queue.
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

`default_nettype wire

// ----- sv/lprd_parser.sv -----
// Parser state and per-byte result generation of the request deframer.
// Depends on lprd_pkg for phase, result and push types.
`timescale 1ns / 1ps
`default_nettype none

module lprd_parser #(
    parameter int MSG_LEN_BITS = lprd_pkg::MSG_LEN_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic [7:0]                        byte_value,
    input  wire logic                              new_connection,
    input  wire logic [lprd_pkg::MAX_MSG_BITS-1:0] max_msg_len,
    input  wire logic [lprd_pkg::MAX_ARG_BITS-1:0] max_arg_cnt,
    output lprd_pkg::push_t                        push
);

    localparam logic [32:0] LEN_MASK = (33'd1 << MSG_LEN_BITS) - 33'd1;

    function automatic lprd_pkg::res_t mk_res(
        input lprd_pkg::kind_t k,
        input logic [7:0]      d,
        input logic [11:0]     idx,
        input logic [20:0]     alen,
        input logic            la,
        input lprd_pkg::err_t  e
    );
        lprd_pkg::res_t r;
        r.kind        = k;
        r.data_byte   = d;
        r.arg_index   = idx;
        r.arg_length  = alen;
        r.last_of_arg = la;
        r.error_code  = e;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    lprd_pkg::phase_t        phase_reg, phase_next, phase_base;
    logic [1:0]              fbc_reg, fbc_next, fbc_base;
    logic [23:0]             shift_reg, shift_next, shift_base, shift_acc;
    logic [MSG_LEN_BITS-1:0] msg_len_reg, msg_len_next, msg_len_base;
    logic [MSG_LEN_BITS-1:0] body_pos_reg, body_pos_next, body_pos_base, body_inc;
    logic [12:0]             args_rem_reg, args_rem_next, args_rem_base, aa_rem;
    logic [11:0]             cur_arg_reg, cur_arg_next, cur_arg_base, aa_idx;
    logic [MSG_LEN_BITS-1:0] left_reg, left_next, left_base, left_dec;

    logic [31:0]             field_val;
    logic                    field_full;
    logic                    too_long;
    logic                    arg_over;
    logic                    aa_end, aa_trail, aa_over, aa_emit;
    lprd_pkg::phase_t        aa_phase;
    lprd_pkg::res_t          aa_res;
    lprd_pkg::res_t          r0, r1;
    logic [1:0]              n;

    // A new connection clears the parser before the byte is looked at.
    always_comb
    begin
        if (new_connection)
        begin
            phase_base    = lprd_pkg::PH_LEN;
            fbc_base      = 2'd0;
            shift_base    = 24'd0;
            msg_len_base  = '0;
            body_pos_base = '0;
            args_rem_base = 13'd0;
            cur_arg_base  = 12'd0;
            left_base     = '0;
        end
        else
        begin
            phase_base    = phase_reg;
            fbc_base      = fbc_reg;
            shift_base    = shift_reg;
            msg_len_base  = msg_len_reg;
            body_pos_base = body_pos_reg;
            args_rem_base = args_rem_reg;
            cur_arg_base  = cur_arg_reg;
            left_base     = left_reg;
        end
    end

    always_comb
    begin
        case (fbc_base)
            2'd0:    shift_acc = {shift_base[23:8], byte_value};
            2'd1:    shift_acc = {shift_base[23:16], byte_value, shift_base[7:0]};
            2'd2:    shift_acc = {byte_value, shift_base[15:0]};
            default: shift_acc = shift_base;
        endcase
    end

    assign field_full = (fbc_base == 2'd3);
    assign field_val  = {byte_value, shift_base};
    assign body_inc   = body_pos_base + 1'b1;
    assign left_dec   = left_base - 1'b1;
    assign too_long   = ({1'b0, field_val} > 33'(max_msg_len)) ||
                        ({1'b0, field_val} > LEN_MASK);
    assign arg_over   = ({1'b0, field_val} + 33'(body_inc)) > 33'(msg_len_base);

    // Shared end-of-argument step: move to the next header or close the body.
    assign aa_idx   = cur_arg_base + 12'd1;
    assign aa_rem   = args_rem_base - 13'd1;
    assign aa_end   = (aa_rem == 13'd0);
    assign aa_trail = (body_inc != msg_len_base);
    assign aa_over  = (33'(body_inc) + 33'd4) > 33'(msg_len_base);
    assign aa_emit  = aa_end || aa_over;

    always_comb
    begin
        if (aa_end)
        begin
            aa_phase = aa_trail ? lprd_pkg::PH_CLOSED : lprd_pkg::PH_LEN;
            aa_res   = aa_trail ?
                mk_res(lprd_pkg::K_ERR, 8'd0, 12'd0, 21'd0, 1'b0, lprd_pkg::E_TRAILING) :
                mk_res(lprd_pkg::K_DONE, 8'd0, 12'd0, 21'd0, 1'b0, lprd_pkg::E_NONE);
        end
        else
        begin
            aa_phase = aa_over ? lprd_pkg::PH_CLOSED : lprd_pkg::PH_ARGLEN;
            aa_res   = mk_res(lprd_pkg::K_ERR, 8'd0, 12'd0, 21'd0, 1'b0,
                              lprd_pkg::E_OVERRUN);
        end
    end

    always_comb
    begin
        phase_next    = phase_base;
        fbc_next      = fbc_base;
        shift_next    = shift_base;
        msg_len_next  = msg_len_base;
        body_pos_next = body_pos_base;
        args_rem_next = args_rem_base;
        cur_arg_next  = cur_arg_base;
        left_next     = left_base;
        n             = 2'd0;
        r0            = mk_res(lprd_pkg::K_DATA, 8'd0, 12'd0, 21'd0, 1'b0, lprd_pkg::E_NONE);
        r1            = r0;

        unique case (phase_base)
            lprd_pkg::PH_LEN:
            begin
                if (field_full)
                begin
                    fbc_next   = 2'd0;
                    shift_next = 24'd0;
                    if (too_long || (field_val < 32'd4))
                    begin
                        phase_next = lprd_pkg::PH_CLOSED;
                        n          = 2'd1;
                        r0 = mk_res(lprd_pkg::K_ERR, 8'd0, 12'd0, 21'd0, 1'b0,
                                    too_long ? lprd_pkg::E_TOO_LONG : lprd_pkg::E_TOO_SHORT);
                    end
                    else
                    begin
                        msg_len_next  = field_val[MSG_LEN_BITS-1:0];
                        body_pos_next = '0;
                        phase_next    = lprd_pkg::PH_COUNT;
                    end
                end
                else
                begin
                    fbc_next   = fbc_base + 2'd1;
                    shift_next = shift_acc;
                end
            end
            lprd_pkg::PH_COUNT:
            begin
                body_pos_next = body_inc;
                if (field_full)
                begin
                    fbc_next   = 2'd0;
                    shift_next = 24'd0;
                    if (field_val > 32'(max_arg_cnt))
                    begin
                        phase_next = lprd_pkg::PH_CLOSED;
                        n          = 2'd1;
                        r0 = mk_res(lprd_pkg::K_ERR, 8'd0, 12'd0, 21'd0, 1'b0,
                                    lprd_pkg::E_TOO_MANY);
                    end
                    else
                    begin
                        args_rem_next = field_val[12:0];
                        cur_arg_next  = 12'd0;
                        if (field_val == 32'd0)
                        begin
                            // No arguments: the body must end right after the count.
                            n          = 2'd1;
                            phase_next = aa_trail ? lprd_pkg::PH_CLOSED : lprd_pkg::PH_LEN;
                            r0 = aa_trail ?
                                mk_res(lprd_pkg::K_ERR, 8'd0, 12'd0, 21'd0, 1'b0,
                                       lprd_pkg::E_TRAILING) :
                                mk_res(lprd_pkg::K_DONE, 8'd0, 12'd0, 21'd0, 1'b0,
                                       lprd_pkg::E_NONE);
                        end
                        else if (aa_over)
                        begin
                            phase_next = lprd_pkg::PH_CLOSED;
                            n          = 2'd1;
                            r0 = mk_res(lprd_pkg::K_ERR, 8'd0, 12'd0, 21'd0, 1'b0,
                                        lprd_pkg::E_OVERRUN);
                        end
                        else
                        begin
                            phase_next = lprd_pkg::PH_ARGLEN;
                        end
                    end
                end
                else
                begin
                    fbc_next   = fbc_base + 2'd1;
                    shift_next = shift_acc;
                end
            end
            lprd_pkg::PH_ARGLEN:
            begin
                body_pos_next = body_inc;
                if (field_full)
                begin
                    fbc_next   = 2'd0;
                    shift_next = 24'd0;
                    if (arg_over)
                    begin
                        phase_next = lprd_pkg::PH_CLOSED;
                        n          = 2'd1;
                        r0 = mk_res(lprd_pkg::K_ERR, 8'd0, 12'd0, 21'd0, 1'b0,
                                    lprd_pkg::E_OVERRUN);
                    end
                    else
                    begin
                        n  = 2'd1;
                        r0 = mk_res(lprd_pkg::K_START, 8'd0, cur_arg_base, field_val[20:0],
                                    1'b0, lprd_pkg::E_NONE);
                        left_next = field_val[MSG_LEN_BITS-1:0];
                        if (field_val == 32'd0)
                        begin
                            // Empty argument: it ends at once.
                            cur_arg_next  = aa_idx;
                            args_rem_next = aa_rem;
                            phase_next    = aa_phase;
                            r1            = aa_res;
                            if (aa_emit)
                            begin
                                n = 2'd2;
                            end
                        end
                        else
                        begin
                            phase_next = lprd_pkg::PH_DATA;
                        end
                    end
                end
                else
                begin
                    fbc_next   = fbc_base + 2'd1;
                    shift_next = shift_acc;
                end
            end
            lprd_pkg::PH_DATA:
            begin
                body_pos_next = body_inc;
                left_next     = left_dec;
                n             = 2'd1;
                r0 = mk_res(lprd_pkg::K_DATA, byte_value, cur_arg_base, 21'd0,
                            (left_dec == '0), lprd_pkg::E_NONE);
                if (left_dec == '0)
                begin
                    cur_arg_next  = aa_idx;
                    args_rem_next = aa_rem;
                    phase_next    = aa_phase;
                    r1            = aa_res;
                    if (aa_emit)
                    begin
                        n = 2'd2;
                    end
                end
            end
            default:
            begin
                phase_next = lprd_pkg::PH_CLOSED;
            end
        endcase

        if (n == 2'd1)
        begin
            r0.last_of_run = 1'b1;
        end
        if (n == 2'd2)
        begin
            r1.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= lprd_pkg::PH_LEN;
            fbc_reg      <= 2'd0;
            shift_reg    <= 24'd0;
            msg_len_reg  <= '0;
            body_pos_reg <= '0;
            args_rem_reg <= 13'd0;
            cur_arg_reg  <= 12'd0;
            left_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            fbc_reg      <= fbc_next;
            shift_reg    <= shift_next;
            msg_len_reg  <= msg_len_next;
            body_pos_reg <= body_pos_next;
            args_rem_reg <= args_rem_next;
            cur_arg_reg  <= cur_arg_next;
            left_reg     <= left_next;
        end
    end

    assign push.n  = accept ? n : 2'd0;
    assign push.r0 = r0;
    assign push.r1 = r1;

endmodule

`default_nettype wire

// ----- sv/lprd_res_fifo.sv -----
// Four-entry result queue taking up to two results a cycle and giving out one when popped.
// Depends on lprd_pkg for the result and push types and the queue size.
`timescale 1ns / 1ps
`default_nettype none

module lprd_res_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lprd_pkg::push_t push,
    input  wire logic            pop,
    output lprd_pkg::res_t       head,
    output logic                 valid,
    output logic                 space_ok
);

    localparam int DEPTH = lprd_pkg::FIFO_DEPTH;
    localparam int PB    = lprd_pkg::FIFO_PTR_BITS;
    localparam int CB    = lprd_pkg::FIFO_CNT_BITS;

    lprd_pkg::res_t  mem_reg [DEPTH];
    logic [PB-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CB-1:0]   count_reg, count_next;
    logic [PB-1:0]   wr_ptr_b;
    logic            do_pop;

    assign do_pop      = pop && valid;
    assign wr_ptr_b    = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + PB'(push.n);
    assign rd_ptr_next = rd_ptr_reg + PB'(do_pop);
    assign count_next  = count_reg + CB'(push.n) - CB'(do_pop);

    assign valid    = (count_reg != '0);
    assign space_ok = (count_reg <= CB'(DEPTH - 2));
    assign head     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_b] <= push.r1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CB'(DEPTH))
        else $error("result queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> space_ok)
        else $error("results pushed without room for two");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && (push.n == 2'd0)) |=> (count_reg == $past(count_reg) - CB'(1)))
        else $error("queue count not reduced by a lone pop");

    a_push_pair: assert property (@(posedge clk) disable iff (!rst_n)
        ((push.n == 2'd2) && !do_pop) |=> (count_reg == $past(count_reg) + CB'(2)))
        else $error("queue count not raised by a pushed pair");

endmodule

`default_nettype wire

// ----- sv/length_prefixed_request_deframer_core.sv -----
// Top level of the length-prefixed request deframer: configuration registers,
// stream ports and the joining of lprd_parser and lprd_res_fifo (uses lprd_pkg).
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Handshake            Payload
// s_*         in         s_tvalid / s_tready  tdata: received byte; tuser: new connection
// m_*         out        m_tvalid / m_tready  tdata: result fields; tuser: kind; tlast
// cfg_*       in         cfg_we (no wait)     cfg_index selects, cfg_data value
//
// Each received word is parsed in the cycle it is accepted; its zero, one or
// two results are written into a four-entry result queue at that same edge.
// The input takes a word in every cycle while the queue holds two or fewer
// results, so one word per cycle is sustained while results leave at least as
// fast as they are made. A stalled output fills the queue and then holds s_tready
// low until room for two results returns. Reset clears parser and queue at once;
// the configuration registers return to 4096 bytes and 1024 arguments.

module length_prefixed_request_deframer_core #(
    parameter int MSG_LEN_BITS = lprd_pkg::MSG_LEN_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Received bytes.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,  // [7:0] byte_value
    input  wire logic                               s_tuser,  // [0] new_connection
    // Parser results.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [7:0] data_byte, [19:8] arg_index, [40:20] arg_length, [41] last_of_arg,
    // [44:42] error_code, [47:45] zero
    output logic [47:0]                             m_tdata,
    output logic [1:0]                              m_tuser,  // [1:0] kind
    output logic                                    m_tlast,  // last_of_run
    // Configuration writes.
    input  wire logic                               cfg_we,
    input  wire logic [lprd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [lprd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    logic [lprd_pkg::MAX_MSG_BITS-1:0] max_msg_len_reg;
    logic [lprd_pkg::MAX_ARG_BITS-1:0] max_arg_cnt_reg;
    logic                              accept;
    logic                              space_ok;
    lprd_pkg::push_t                   push;
    lprd_pkg::res_t                    head;

    // Writes to an index outside the register list are simply dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_msg_len_reg <= lprd_pkg::MAX_MSG_RESET;
            max_arg_cnt_reg <= lprd_pkg::MAX_ARG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lprd_pkg::REG_MAX_MSG_LEN:
                begin
                    max_msg_len_reg <= cfg_data[lprd_pkg::MAX_MSG_BITS-1:0];
                end
                lprd_pkg::REG_MAX_ARG_CNT:
                begin
                    max_arg_cnt_reg <= cfg_data[lprd_pkg::MAX_ARG_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The input side only looks at queue room, never at m_tready directly.
    assign s_tready = space_ok;
    assign accept   = s_tvalid && s_tready;

    lprd_parser #(
        .MSG_LEN_BITS (MSG_LEN_BITS)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .byte_value     (s_tdata),
        .new_connection (s_tuser),
        .max_msg_len    (max_msg_len_reg),
        .max_arg_cnt    (max_arg_cnt_reg),
        .push           (push)
    );

    lprd_res_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (m_tready),
        .head     (head),
        .valid    (m_tvalid),
        .space_ok (space_ok)
    );

    assign m_tdata = {3'b000, head.error_code, head.last_of_arg, head.arg_length,
                      head.arg_index, head.data_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

endmodule

`default_nettype wire

// ----- tb/length_prefixed_request_deframer_core_tb.sv -----
// Self-checking testbench for length_prefixed_request_deframer_core (uses lprd_pkg).
// Drives request byte streams through random stalls, predicts every result word and
// compares it field by field with what the deframer delivers.
`timescale 1ns / 1ps

module length_prefixed_request_deframer_core_tb;

    // Indexes that select no register; writes to them must change nothing.
    localparam logic [lprd_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_LO = 2'd2;
    localparam logic [lprd_pkg::CFG_IDX_BITS-1:0] REG_UNUSED_HI = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_BYTES = 140;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [7:0]                         s_tdata = 8'd0;
    logic                               s_tuser = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [47:0]                        m_tdata;
    logic [1:0]                         m_tuser;
    logic                               m_tlast;
    logic                               cfg_we = 1'b0;
    logic [lprd_pkg::CFG_IDX_BITS-1:0]  cfg_index = lprd_pkg::REG_MAX_MSG_LEN;
    logic [lprd_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    length_prefixed_request_deframer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Parser copy kept in step with every accepted word.
    lprd_pkg::phase_t p_phase;
    logic [1:0]       p_nbytes;
    logic [31:0]      p_field;
    logic [20:0]      p_msg_len;
    logic [20:0]      p_body_pos;
    logic [12:0]      p_args_left;
    logic [11:0]      p_arg_idx;
    logic [20:0]      p_arg_left;
    logic [20:0]      p_max_msg;
    logic [12:0]      p_max_arg;

    // Results of the byte being parsed, then the store of results still owed.
    lprd_pkg::res_t   step_out [2];
    int               step_n;
    lprd_pkg::res_t   pending_results [$];

    // Stimulus side: what the generator believes the registers hold.
    logic [20:0] gen_max_msg = lprd_pkg::MAX_MSG_RESET;
    logic [12:0] gen_max_arg = lprd_pkg::MAX_ARG_RESET;
    logic [7:0]  frame_bytes [$];
    logic        stream_clean = 1'b0;
    logic        quiet_tail = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned sink_hold = 0;
    int unsigned stall_cycles = 0;
    int          fault_count = 0;

    task automatic clear_parser();
        p_phase     = lprd_pkg::PH_LEN;
        p_nbytes    = '0;
        p_field     = '0;
        p_msg_len   = '0;
        p_body_pos  = '0;
        p_args_left = '0;
        p_arg_idx   = '0;
        p_arg_left  = '0;
    endtask

    task automatic add_result(input lprd_pkg::kind_t k, input logic [7:0] d,
                              input logic [11:0] idx, input logic [20:0] alen,
                              input logic last_arg, input lprd_pkg::err_t e);
        lprd_pkg::res_t r;
        r.kind        = k;
        r.data_byte   = d;
        r.arg_index   = idx;
        r.arg_length  = alen;
        r.last_of_arg = last_arg;
        r.error_code  = e;
        r.last_of_run = 1'b0;
        step_out[step_n] = r;
        step_n++;
    endtask

    task automatic close_with(input lprd_pkg::err_t e);
        p_phase = lprd_pkg::PH_CLOSED;
        add_result(lprd_pkg::K_ERR, 8'd0, 12'd0, 21'd0, 1'b0, e);
    endtask

    // Little-endian field assembly; complete is set on the fourth byte.
    task automatic take_field_byte(input logic [7:0] b, output logic complete,
                                   output logic [31:0] value);
        p_field  = p_field | ({24'd0, b} << (8 * p_nbytes));
        complete = (p_nbytes == 2'd3);
        value    = p_field;
        p_nbytes = p_nbytes + 1'b1;
        if (complete)
            p_field = '0;
    endtask

    task automatic finish_args();
        if (p_body_pos != p_msg_len)
            close_with(lprd_pkg::E_TRAILING);
        else
        begin
            p_phase  = lprd_pkg::PH_LEN;
            p_nbytes = '0;
            p_field  = '0;
            add_result(lprd_pkg::K_DONE, 8'd0, 12'd0, 21'd0, 1'b0, lprd_pkg::E_NONE);
        end
    endtask

    // An argument header must fit in what is left of the body.
    task automatic open_next_arg();
        if (({1'b0, p_body_pos} + 22'd4) > {1'b0, p_msg_len})
            close_with(lprd_pkg::E_OVERRUN);
        else
        begin
            p_phase  = lprd_pkg::PH_ARGLEN;
            p_nbytes = '0;
            p_field  = '0;
        end
    endtask

    task automatic arg_done();
        p_arg_idx   = p_arg_idx + 1'b1;
        p_args_left = p_args_left - 1'b1;
        if (p_args_left == 0)
            finish_args();
        else
            open_next_arg();
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic nc);
        logic [31:0]    v;
        logic           complete;
        lprd_pkg::res_t r;
        step_n = 0;
        if (nc)
            clear_parser();
        case (p_phase)
            lprd_pkg::PH_LEN:
            begin
                take_field_byte(b, complete, v);
                if (complete)
                begin
                    // The length check comes before the short check.
                    if (v > {11'd0, p_max_msg})
                        close_with(lprd_pkg::E_TOO_LONG);
                    else if (v < 32'd4)
                        close_with(lprd_pkg::E_TOO_SHORT);
                    else
                    begin
                        p_msg_len  = v[20:0];
                        p_body_pos = '0;
                        p_phase    = lprd_pkg::PH_COUNT;
                    end
                end
            end
            lprd_pkg::PH_COUNT:
            begin
                p_body_pos = p_body_pos + 1'b1;
                take_field_byte(b, complete, v);
                if (complete)
                begin
                    if (v > {19'd0, p_max_arg})
                        close_with(lprd_pkg::E_TOO_MANY);
                    else
                    begin
                        p_args_left = v[12:0];
                        p_arg_idx   = '0;
                        if (v == 0)
                            finish_args();
                        else
                            open_next_arg();
                    end
                end
            end
            lprd_pkg::PH_ARGLEN:
            begin
                p_body_pos = p_body_pos + 1'b1;
                take_field_byte(b, complete, v);
                if (complete)
                begin
                    if (({1'b0, v} + {12'd0, p_body_pos}) > {12'd0, p_msg_len})
                        close_with(lprd_pkg::E_OVERRUN);
                    else
                    begin
                        add_result(lprd_pkg::K_START, 8'd0, p_arg_idx, v[20:0], 1'b0,
                                   lprd_pkg::E_NONE);
                        p_arg_left = v[20:0];
                        if (v == 0)
                            arg_done();
                        else
                            p_phase = lprd_pkg::PH_DATA;
                    end
                end
            end
            lprd_pkg::PH_DATA:
            begin
                p_body_pos = p_body_pos + 1'b1;
                p_arg_left = p_arg_left - 1'b1;
                add_result(lprd_pkg::K_DATA, b, p_arg_idx, 21'd0, p_arg_left == 0,
                           lprd_pkg::E_NONE);
                if (p_arg_left == 0)
                    arg_done();
            end
            default:
                p_phase = lprd_pkg::PH_CLOSED;
        endcase
        for (int i = 0; i < step_n; i++)
        begin
            r = step_out[i];
            r.last_of_run = (i == step_n - 1);
            pending_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fault_count++;
        end
    endtask

    // Register writes, result words and received words are all taken at the edge, in
    // that order, so that the prediction never depends on process scheduling.
    always @(posedge clk)
    begin : monitor
        lprd_pkg::res_t want;
        if (!rst_n)
        begin
            clear_parser();
            p_max_msg = lprd_pkg::MAX_MSG_RESET;
            p_max_arg = lprd_pkg::MAX_ARG_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == lprd_pkg::REG_MAX_MSG_LEN)
                    p_max_msg = cfg_data;
                else if (cfg_index == lprd_pkg::REG_MAX_ARG_CNT)
                    p_max_arg = cfg_data[12:0];
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result word with none pending: kind %0d, tdata 0x%0h",
                           m_tuser, m_tdata);
                    fault_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("data_byte", want.data_byte, m_tdata[7:0]);
                    check_field("arg_index", want.arg_index, m_tdata[19:8]);
                    check_field("arg_length", want.arg_length, m_tdata[40:20]);
                    check_field("last_of_arg", want.last_of_arg, m_tdata[41]);
                    check_field("error_code", want.error_code, m_tdata[44:42]);
                    check_field("tdata padding", 32'd0, m_tdata[47:45]);
                    check_field("last_of_run", want.last_of_run, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                deframe_byte(s_tdata, s_tuser);
        end
    end

    // The watchdog ends a run in which no word moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Result sink: stalls come in bursts of random length.
    always @(posedge clk)
    begin
        if (quiet_tail)
            m_tready <= 1'b1;
        else if (sink_hold > 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= $urandom_range(0, 3);
        end
        else
            m_tready <= 1'b1;
    end

    // tvalid is left high on return so that the next word follows without a gap;
    // every waiting task lowers it first.
    task automatic send_byte(input logic [7:0] value, input logic nc);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= nc;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic push_word(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            frame_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic send_frame(input logic fresh);
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], fresh && (i == 0));
        frame_bytes.delete();
    endtask

    // Holds the sender back until every owed result has been delivered.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [20:0] msg_data, input logic [20:0] arg_data);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= lprd_pkg::REG_MAX_MSG_LEN;
        cfg_data  <= msg_data;
        @(posedge clk);
        cfg_index <= lprd_pkg::REG_MAX_ARG_CNT;
        cfg_data  <= arg_data;
        @(posedge clk);
        cfg_index <= ($urandom_range(0, 1) != 0) ? REG_UNUSED_LO : REG_UNUSED_HI;
        cfg_data  <= $urandom_range(0, 21'h1FFFFF);
        @(posedge clk);
        cfg_we      <= 1'b0;
        gen_max_msg = msg_data;
        gen_max_arg = arg_data[12:0];
    endtask

    task automatic test_too_short();
        // A length of three closes the connection; the byte after it is ignored.
        push_word(32'd3);
        frame_bytes.push_back(8'hFF);
        send_frame(1'b1);
    endtask

    task automatic test_too_long();
        push_word(32'hFFFF_FFFF);
        send_frame(1'b1);
    endtask

    task automatic test_too_many();
        push_word(32'd4);
        push_word({19'd0, lprd_pkg::MAX_ARG_RESET} + 32'd1);
        send_frame(1'b1);
    endtask

    task automatic test_two_arguments();
        // An empty argument, then one with the extreme byte values; the last data
        // byte also completes the message.
        push_word(32'd14);
        push_word(32'd2);
        push_word(32'd0);
        push_word(32'd2);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        send_frame(1'b1);
        stream_clean = 1'b1;
    endtask

    // One request: mostly well formed with random contents, the rest carrying one
    // kind of fault, cut short, or plain noise.
    task automatic random_request();
        int unsigned mode;
        int unsigned nargs;
        int unsigned body;
        int unsigned keep;
        int unsigned span;
        int unsigned alen [6];
        logic [31:0] len_word;
        logic [31:0] cnt_word;
        logic        fresh;
        mode  = $urandom_range(0, 19);
        nargs = $urandom_range(0, 5);
        if (nargs > gen_max_arg)
            nargs = gen_max_arg;
        body = 4;
        for (int i = 0; i < nargs; i++)
        begin
            alen[i] = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
            body += 4 + alen[i];
        end
        len_word = body;
        cnt_word = nargs;
        case (mode)
            11: len_word = body + $urandom_range(1, 3);
            12: len_word = (body > 4) ? $urandom_range(4, body - 1) : 0;
            13: cnt_word = ($urandom_range(0, 1) != 0) ?
                           {19'd0, gen_max_arg} + $urandom_range(1, 3) : $urandom();
            14: len_word = ($urandom_range(0, 1) != 0) ?
                           {11'd0, gen_max_msg} + $urandom_range(1, 64) : $urandom();
            15: len_word = $urandom_range(0, 3);
            default: ;
        endcase
        fresh = !stream_clean || ($urandom_range(0, 7) == 0);
        if (mode == 17)
        begin
            // Noise, with new connections falling anywhere in it.
            span = $urandom_range(1, 12);
            for (int i = 0; i < span; i++)
                send_byte($urandom_range(0, 255),
                          (fresh && i == 0) || ($urandom_range(0, 3) == 0));
            stream_clean = 1'b0;
        end
        else if (mode == 18 && gen_max_msg >= 16)
        begin
            // A single argument as long as the body allows, or one byte more, then
            // abandoned after a few data bytes.
            len_word = ($urandom_range(0, 1) != 0) ? gen_max_msg :
                       $urandom_range(12, gen_max_msg);
            push_word(len_word);
            push_word(32'd1);
            push_word(len_word - 8 + $urandom_range(0, 1));
            span = $urandom_range(1, 4);
            for (int i = 0; i < span; i++)
                frame_bytes.push_back($urandom_range(0, 255));
            send_frame(fresh);
            stream_clean = 1'b0;
        end
        else
        begin
            push_word(len_word);
            push_word(cnt_word);
            for (int i = 0; i < nargs; i++)
            begin
                push_word(alen[i]);
                for (int j = 0; j < alen[i]; j++)
                    frame_bytes.push_back($urandom_range(0, 255));
            end
            while (frame_bytes.size() < len_word + 4 && mode == 11)
                frame_bytes.push_back($urandom_range(0, 255));
            if (mode == 16)
            begin
                keep = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > keep)
                    frame_bytes.delete(frame_bytes.size() - 1);
            end
            send_frame(fresh);
            stream_clean = (mode <= 10 || mode == 19 || mode == 18) && body <= gen_max_msg;
        end
    endtask

    // Register settings in turn, the extremes first; the last phase runs without
    // idling on either side.
    task automatic test_config_phases();
        int unsigned phase_start;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: configure(21'd0, 21'd0);
                1: configure(21'h1FFFFF, ($urandom_range(0, 21'h1FFFFF) & 21'h1FE000) |
                                         21'h001FFF);
                2: configure(lprd_pkg::MAX_MSG_RESET, {8'd0, lprd_pkg::MAX_ARG_RESET});
                3: configure($urandom_range(0, 21'h1FFFFF), $urandom_range(0, 8191));
                default: configure($urandom_range(8, 96), $urandom_range(0, 6));
            endcase
            if (p == 7)
                quiet_tail = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_request();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_too_short();
        test_too_long();
        test_too_many();
        test_two_arguments();
        test_config_phases();
        settle();
        repeat (4) @(posedge clk);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
sv/lprd_pkg.sv
sv/lprd_parser.sv
sv/lprd_res_fifo.sv
sv/length_prefixed_request_deframer_core.sv
tb/length_prefixed_request_deframer_core_tb.sv
